### sv/integer_to_ascii_formatter_macros.svh
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ITA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, held off while reset is asserted.
`define ITA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/ita_pkg.sv
// Types, constants and helper functions for the integer to ASCII formatter.
package ita_pkg;

	localparam logic [1:0] ITA_ACT_SDEC = 2'd0;
	localparam logic [1:0] ITA_ACT_UDEC = 2'd1;
	localparam logic [1:0] ITA_ACT_HEX  = 2'd2;

	localparam int ITA_QDEPTH = 2;

	localparam logic [3:0] ITA_DEC_TOP = 4'd9;
	localparam logic [3:0] ITA_HEX_TOP = 4'd7;

	localparam logic [7:0] ITA_CHR_ZERO  = 8'h30;
	localparam logic [7:0] ITA_CHR_ALPHA = 8'h41;
	localparam logic [7:0] ITA_CHR_MINUS = 8'h2D;
	localparam logic [3:0] ITA_RADIX_DEC = 4'd10;

	typedef struct packed {
		logic        hex;
		logic        neg;
		logic [31:0] mag;
	} ita_item_t;

	function automatic logic [33:0] ita_pow10(input logic [3:0] pos);
		logic [33:0] p;
		unique case (pos)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = 34'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] ita_digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < ITA_RADIX_DEC) begin
			c = ITA_CHR_ZERO + {4'd0, d};
		end else begin
			c = ITA_CHR_ALPHA + {4'd0, d - ITA_RADIX_DEC};
		end
		return c;
	endfunction

endpackage

### sv/integer_to_ascii_formatter.sv
// Integer to ASCII formatter top level: classifier, request queue, digit generator.
// The digit generator steps through leading zero positions without emitting a character,
// then gives one character per cycle while the output is free or popped.
// The digit generator handles one request at a time; a queued request is taken only
// when the generator is idle.
// Reset: arst_n clears the request queue, the generator and the output valid flag.
module integer_to_ascii_formatter import ita_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [31:0] number,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  character,
	output logic        last
);

	logic      q_wr;
	ita_item_t q_wr_item;
	logic      q_rd;
	ita_item_t q_rd_item;
	logic      q_empty;

	ita_front u_front (
		.action (action),
		.number (number),
		.push   (push),
		.q_wr   (q_wr),
		.q_item (q_wr_item)
	);

	ita_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_wr_item),
		.full    (full),
		.rd      (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	ita_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_rd_item),
		.q_rd      (q_rd),
		.character (character),
		.last      (last),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

### sv/ita_fifo.sv
// Short request queue between the classifier and the digit generator.
module ita_fifo import ita_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  ita_item_t wr_item,
	output logic      full,
	input  logic      rd,
	output ita_item_t rd_item,
	output logic      empty
);

	localparam int PW = (ITA_QDEPTH > 1) ? $clog2(ITA_QDEPTH) : 1;
	localparam int CW = $clog2(ITA_QDEPTH + 1);

	ita_item_t         mem_q [ITA_QDEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [CW-1:0]     count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CW'(ITA_QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(ITA_QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(ITA_QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/ita_front.sv
// Request classifier: decodes the format and forms the sign and magnitude.
module ita_front import ita_pkg::*; (
	input  logic [1:0]  action,
	input  logic [31:0] number,
	input  logic        push,
	output logic        q_wr,
	output ita_item_t   q_item
);

	logic hex;
	logic neg;

	assign hex = action[1];
	assign neg = (action == ITA_ACT_SDEC) && number[31];

	assign q_wr       = push;
	assign q_item.hex = hex;
	assign q_item.neg = neg;
	assign q_item.mag = neg ? (~number + 32'd1) : number;

endmodule

### sv/ita_back.sv
// Digit generator: emits one character per cycle while the output is free or popped, most significant first.
`include "integer_to_ascii_formatter_macros.svh"

module ita_back import ita_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  ita_item_t   q_item,
	output logic        q_rd,
	output logic [7:0]  character,
	output logic        last,
	output logic        empty,
	input  logic        pop
);

	logic        busy_q;
	logic        hex_q;
	logic        sign_q;
	logic        started_q;
	logic [31:0] mag_q;
	logic [3:0]  pos_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        valid_q;

	logic        slot_free;
	logic        step;
	logic        load_out;
	logic [3:0]  dig;
	logic [33:0] sub;
	logic [33:0] magx;
	logic [33:0] pw;
	logic [33:0] cand;
	logic        emit_dig;
	logic [7:0]  next_char;
	logic        next_last;

	assign slot_free = !valid_q || pop;
	assign q_rd      = !busy_q && !q_empty;
	assign step      = busy_q && slot_free;

	always_comb begin
		magx = {2'b00, mag_q};
		pw   = ita_pow10(pos_q);
		dig  = '0;
		sub  = '0;
		cand = '0;
		if (hex_q) begin
			dig = mag_q[31:28];
		end else begin
			for (int j = 1; j < 10; j++) begin
				cand = pw * 34'(j);
				if (magx >= cand) begin
					dig = 4'(j);
					sub = cand;
				end
			end
		end
	end

	assign emit_dig  = (dig != '0) || started_q || (pos_q == '0);
	assign load_out  = step && (sign_q || emit_dig);
	assign next_char = sign_q ? ITA_CHR_MINUS : ita_digit_char(dig);
	assign next_last = !sign_q && (pos_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			sign_q    <= 1'b0;
			started_q <= 1'b0;
			hex_q     <= 1'b0;
			pos_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (q_rd) begin
				busy_q    <= 1'b1;
				hex_q     <= q_item.hex;
				sign_q    <= q_item.neg;
				started_q <= 1'b0;
				pos_q     <= q_item.hex ? ITA_HEX_TOP : ITA_DEC_TOP;
			end else if (step) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					started_q <= started_q || emit_dig;
					pos_q     <= pos_q - 4'd1;
					if (pos_q == '0) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (load_out) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			mag_q <= q_item.mag;
		end else if (step && !sign_q) begin
			mag_q <= hex_q ? {mag_q[27:0], 4'd0} : (mag_q - sub[31:0]);
		end
		if (load_out) begin
			char_q <= next_char;
			last_q <= next_last;
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign empty     = !valid_q;

	`ITA_ASSERT_IMP(a_last_ends_busy, step && next_last, ##1 !busy_q,
		"digit generator still busy after the final character")
	`ITA_ASSERT_IMP(a_sign_dec_only, busy_q && sign_q, !hex_q && !started_q,
		"minus sign pending on a hex request or after digits")
	`ITA_ASSERT_IMP(a_hex_pos_range, busy_q && hex_q, pos_q <= ITA_HEX_TOP,
		"hex digit position out of range")
	`ITA_ASSERT_IMP(a_dec_digit_range, busy_q && !hex_q && !sign_q, dig < ITA_RADIX_DEC,
		"decimal digit out of range")

endmodule
